[src/stl_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and character tables of the source text lexer
// no dependencies
package stl_pkg;

    localparam int MAX_RES    = 3;
    localparam int FIFO_DEPTH = 4;

    localparam int MAX_TOKEN_LEN_DEF = 255;
    localparam int LINE_BITS_DEF     = 20;
    localparam int COLUMN_BITS_DEF   = 16;

    localparam int KIND_W = 5;
    localparam int LINE_W = 20;
    localparam int COL_W  = 16;
    localparam int LEN_W  = 8;

    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_SLASH  = 3'd1;
    localparam logic [2:0] M_BLOCK  = 3'd2;
    localparam logic [2:0] M_LINE   = 3'd3;
    localparam logic [2:0] M_STRING = 3'd4;
    localparam logic [2:0] M_OPER   = 3'd5;
    localparam logic [2:0] M_IDENT  = 3'd6;

    localparam logic [KIND_W-1:0] K_END      = 5'd0;
    localparam logic [KIND_W-1:0] K_KEYWORD0 = 5'd8;
    localparam logic [KIND_W-1:0] K_STRING   = 5'd16;
    localparam logic [KIND_W-1:0] K_OPER     = 5'd17;
    localparam logic [KIND_W-1:0] K_IDENT    = 5'd18;

    localparam logic [7:0] C_NL    = 8'h0A;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_RBRK  = 8'h5D;
    localparam logic [7:0] C_UNDER = 8'h5F;

    localparam logic [63:0] KW_STR [8] = '{
        64'("func"), 64'("struct"), 64'("if"), 64'("else"),
        64'("while"), 64'("return"), 64'("break"), 64'("continue")
    };
    localparam logic [3:0] KW_LEN [8] = '{4'd4, 4'd6, 4'd2, 4'd4, 4'd5, 4'd6, 4'd5, 4'd8};
    localparam logic [7:0] PUNCT [7] = '{"{", "}", "(", ")", ":", ",", ";"};

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
        logic [LEN_W-1:0]  len;
        logic              sat;
        logic              unterm;
        logic              last;
    } res_t;

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] idx);
        logic [3:0] pos;
        pos = KW_LEN[k] - 4'd1 - {1'b0, idx};
        return KW_STR[k][{pos[2:0], 3'b000} +: 8];
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "=" ||
               c == "<" || c == ">" || c == "." || c == "[" || c == "]";
    endfunction

    function automatic res_t mk_res(input logic [KIND_W-1:0] kind, input logic [31:0] line,
                                    input logic [31:0] col, input logic [31:0] len,
                                    input logic sat, input logic unterm);
        res_t r;
        r.kind   = kind;
        r.line   = line[LINE_W-1:0];
        r.col    = col[COL_W-1:0];
        r.len    = len[LEN_W-1:0];
        r.sat    = sat;
        r.unterm = unterm;
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

[src/source_text_lexer_top.sv]
`timescale 1ns / 1ps
// top level of the source text lexer: input register, lexer core, result queue
// depends on stl_pkg, stl_core, stl_fifo
//
// input stream s_*: one source byte per transfer in s_tdata, s_tlast marks the
// final byte of a text; it flushes any open token and then an end token follows.
// output stream m_*: one token descriptor per transfer, kind in m_tuser, m_tlast
// set on the last descriptor caused by one input byte.
// a byte is registered on transfer and lexed once the queue has room, its results
// are registered into a four-entry queue whose head drives the output port.
// one byte per cycle is taken while each byte yields at most one descriptor and
// the receiver is ready; bytes yielding two or three cost extra cycles on the output
// port, which drains one descriptor per cycle while m_tready is high.
// a byte is lexed only when the queue holds at most one entry; while the
// receiver stalls the queue fills and s_tready drops after one more byte.
// reset clears the lexer to idle, line 1, column 0 and empties the queue.
module source_text_lexer_top #(
    parameter int MAX_TOKEN_LEN = stl_pkg::MAX_TOKEN_LEN_DEF,
    parameter int LINE_BITS     = stl_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS   = stl_pkg::COLUMN_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // line_number, column, token_length, length_saturated,
                                   // unterminated, zero fill
    output logic [4:0]  m_tuser,   // token_kind
    output logic        m_tlast    // last_result
);

    logic          in_valid_reg;
    logic [7:0]    byte_reg;
    logic          eot_reg;
    logic          adv;
    logic          room;
    logic [2:0]    level;
    logic [1:0]    res_n;
    stl_pkg::res_t res [stl_pkg::MAX_RES];
    stl_pkg::res_t head;

    assign adv      = in_valid_reg && room;
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            byte_reg <= s_tdata;
            eot_reg  <= s_tlast;
        end
    end

    stl_core #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .LINE_BITS     (LINE_BITS),
        .COLUMN_BITS   (COLUMN_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (adv),
        .text_byte   (byte_reg),
        .end_of_text (eot_reg),
        .res_n       (res_n),
        .res         (res)
    );

    stl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (adv ? res_n : 2'd0),
        .push_data (res),
        .pop       (m_tready),
        .out_valid (m_tvalid),
        .out_data  (head),
        .room      (room),
        .level     (level)
    );

    assign m_tdata = {2'b00, head.unterm, head.sat, head.len, head.col, head.line};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    // queue never overflows
    assert property (@(posedge clk) disable iff (!rst_n)
        level <= 3'(stl_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // a final byte always ends with an end token carrying the last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && eot_reg) |-> (res_n != 2'd0 && res[res_n - 2'd1].kind == stl_pkg::K_END
                              && res[res_n - 2'd1].last))
        else $error("end of text without end token");

    // a byte is lexed only with room for all of its results
    assert property (@(posedge clk) disable iff (!rst_n)
        adv |-> (32'(level) + 32'(res_n) <= 32'(stl_pkg::FIFO_DEPTH)))
        else $error("results pushed without room");

endmodule

[src/stl_core.sv]
`timescale 1ns / 1ps
// lexer state and per-byte next-state logic, up to three token results per byte
// depends on stl_pkg
module stl_core #(
    parameter int MAX_TOKEN_LEN = stl_pkg::MAX_TOKEN_LEN_DEF,
    parameter int LINE_BITS     = stl_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS   = stl_pkg::COLUMN_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          text_byte,
    input  logic                end_of_text,
    output logic [1:0]          res_n,
    output stl_pkg::res_t       res [stl_pkg::MAX_RES]
);

    localparam int LEN_BITS = $clog2(MAX_TOKEN_LEN + 1);

    logic [2:0]             mode_reg, mode_next;
    logic [LEN_BITS-1:0]    plen_reg, plen_next;
    logic                   pover_reg, pover_next;
    logic [7:0]             kwc_reg, kwc_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic                   star_reg, star_next;

    always_comb
    begin
        logic                   used;
        logic                   nl;
        logic                   done;
        logic [7:0]             c;
        logic [COLUMN_BITS-1:0] col;
        logic                   sv [4];
        stl_pkg::res_t          sr [4];
        logic [2:0]             n;

        c          = text_byte;
        col        = col_reg;
        used       = 1'b0;
        nl         = 1'b0;
        done       = 1'b0;
        mode_next  = mode_reg;
        plen_next  = plen_reg;
        pover_next = pover_reg;
        kwc_next   = kwc_reg;
        line_next  = line_reg;
        star_next  = star_reg;
        for (int i = 0; i < 4; i++)
        begin
            sv[i] = 1'b0;
            sr[i] = '0;
        end

        if (mode_next == stl_pkg::M_SLASH)
        begin
            if (c == stl_pkg::C_STAR)
            begin
                mode_next = stl_pkg::M_BLOCK;
                star_next = 1'b1;
                used      = 1'b1;
            end
            else if (c == stl_pkg::C_SLASH)
            begin
                mode_next = stl_pkg::M_LINE;
                used      = 1'b1;
            end
            else
            begin
                mode_next  = stl_pkg::M_OPER;
                plen_next  = LEN_BITS'(1);
                pover_next = 1'b0;
            end
        end
        if (!used && mode_next == stl_pkg::M_BLOCK)
        begin
            used = 1'b1;
            if (star_next && c == stl_pkg::C_SLASH)
            begin
                mode_next = stl_pkg::M_IDLE;
                star_next = 1'b0;
            end
            else
                star_next = (c == stl_pkg::C_STAR);
        end
        if (!used && mode_next == stl_pkg::M_LINE)
        begin
            if (c == stl_pkg::C_NL)
                mode_next = stl_pkg::M_IDLE;
            else
                used = 1'b1;
        end
        if (!used && mode_next == stl_pkg::M_STRING)
        begin
            used = 1'b1;
            if (32'(plen_next) < 32'(MAX_TOKEN_LEN))
                plen_next = plen_next + LEN_BITS'(1);
            else
                pover_next = 1'b1;
            if (c == stl_pkg::C_QUOTE)
            begin
                sv[0] = 1'b1;
                sr[0] = stl_pkg::mk_res(stl_pkg::K_STRING, 32'(line_reg), 32'(col) + 32'd1,
                                        32'(plen_next), pover_next, 1'b0);
                mode_next = stl_pkg::M_IDLE;
            end
        end
        if (!used && mode_next == stl_pkg::M_OPER)
        begin
            if (stl_pkg::is_op(c))
            begin
                used = 1'b1;
                if (32'(plen_next) < 32'(MAX_TOKEN_LEN))
                    plen_next = plen_next + LEN_BITS'(1);
                else
                    pover_next = 1'b1;
                if (c == stl_pkg::C_RBRK || 32'(plen_next) >= 32'd3)
                begin
                    sv[0] = 1'b1;
                    sr[0] = stl_pkg::mk_res(stl_pkg::K_OPER, 32'(line_reg),
                                            32'(col) + 32'd1, 32'(plen_next), pover_next, 1'b0);
                    mode_next = stl_pkg::M_IDLE;
                end
            end
            else
            begin
                sv[0] = 1'b1;
                sr[0] = stl_pkg::mk_res(stl_pkg::K_OPER, 32'(line_reg), 32'(col),
                                        32'(plen_next), pover_next, 1'b0);
                mode_next = stl_pkg::M_IDLE;
            end
        end
        if (!used && mode_next == stl_pkg::M_IDENT)
        begin
            if (stl_pkg::is_alnum(c) || c == stl_pkg::C_UNDER)
            begin
                used = 1'b1;
                for (int k = 0; k < 8; k++)
                begin
                    if (!(32'(plen_next) < 32'(stl_pkg::KW_LEN[k]) &&
                          stl_pkg::kw_char(3'(k), plen_next[2:0]) == c))
                        kwc_next[k] = 1'b0;
                end
                if (32'(plen_next) < 32'(MAX_TOKEN_LEN))
                    plen_next = plen_next + LEN_BITS'(1);
                else
                    pover_next = 1'b1;
            end
            else
            begin
                if (stl_pkg::is_space(c))
                begin
                    for (int k = 0; k < 8; k++)
                    begin
                        if (!done && kwc_next[k] &&
                            32'(stl_pkg::KW_LEN[k]) == 32'(plen_next))
                        begin
                            done  = 1'b1;
                            sv[0] = 1'b1;
                            sr[0] = stl_pkg::mk_res(
                                stl_pkg::K_KEYWORD0 + stl_pkg::KIND_W'(k), 32'(line_reg),
                                32'(col) - 32'(plen_next), 32'(plen_next), 1'b0, 1'b0);
                        end
                    end
                end
                if (!done)
                begin
                    sv[0] = 1'b1;
                    sr[0] = stl_pkg::mk_res(stl_pkg::K_IDENT, 32'(line_reg), 32'(col),
                                            32'(plen_next), pover_next, 1'b0);
                end
                mode_next = stl_pkg::M_IDLE;
            end
        end
        if (!used)
        begin
            if (c == stl_pkg::C_NL)
            begin
                nl = 1'b1;
                if (line_next != {LINE_BITS{1'b1}})
                    line_next = line_next + LINE_BITS'(1);
            end
            else if (stl_pkg::is_space(c))
            begin
                mode_next = mode_next;
            end
            else if (c == stl_pkg::C_SLASH)
                mode_next = stl_pkg::M_SLASH;
            else if (c == stl_pkg::C_QUOTE)
            begin
                mode_next  = stl_pkg::M_STRING;
                plen_next  = LEN_BITS'(1);
                pover_next = 1'b0;
            end
            else if (stl_pkg::is_op(c))
            begin
                mode_next  = stl_pkg::M_OPER;
                plen_next  = LEN_BITS'(1);
                pover_next = 1'b0;
                if (c == stl_pkg::C_RBRK)
                begin
                    sv[1] = 1'b1;
                    sr[1] = stl_pkg::mk_res(stl_pkg::K_OPER, 32'(line_next), 32'(col) + 32'd1,
                                            32'd1, 1'b0, 1'b0);
                    mode_next = stl_pkg::M_IDLE;
                end
            end
            else if (stl_pkg::is_alnum(c))
            begin
                mode_next  = stl_pkg::M_IDENT;
                plen_next  = LEN_BITS'(1);
                pover_next = 1'b0;
                for (int k = 0; k < 8; k++)
                    kwc_next[k] = (stl_pkg::kw_char(3'(k), 3'd0) == c);
            end
            else
            begin
                for (int k = 0; k < 7; k++)
                begin
                    if (stl_pkg::PUNCT[k] == c)
                    begin
                        sv[1] = 1'b1;
                        sr[1] = stl_pkg::mk_res(stl_pkg::KIND_W'(k + 1), 32'(line_next),
                                                32'(col), 32'd1, 1'b0, 1'b0);
                    end
                end
            end
        end

        col_next = nl ? COLUMN_BITS'(1) : col + COLUMN_BITS'(1);

        if (end_of_text)
        begin
            if (mode_next == stl_pkg::M_STRING)
            begin
                sv[2] = 1'b1;
                sr[2] = stl_pkg::mk_res(stl_pkg::K_STRING, 32'(line_next), 32'(col_next),
                                        32'(plen_next), pover_next, 1'b1);
            end
            else if (mode_next == stl_pkg::M_OPER || mode_next == stl_pkg::M_IDENT)
            begin
                sv[2] = 1'b1;
                sr[2] = stl_pkg::mk_res(
                    (mode_next == stl_pkg::M_OPER) ? stl_pkg::K_OPER : stl_pkg::K_IDENT,
                    32'(line_next), 32'(col_next), 32'(plen_next), pover_next, 1'b0);
            end
            else if (mode_next == stl_pkg::M_SLASH)
            begin
                sv[2] = 1'b1;
                sr[2] = stl_pkg::mk_res(stl_pkg::K_OPER, 32'(line_next), 32'(col_next),
                                        32'd1, 1'b0, 1'b0);
            end
            sv[3] = 1'b1;
            sr[3] = stl_pkg::mk_res(stl_pkg::K_END, 32'(line_next), 32'(col_next),
                                    32'd0, 1'b0, 1'b0);
            mode_next  = stl_pkg::M_IDLE;
            plen_next  = '0;
            pover_next = 1'b0;
            kwc_next   = '0;
            line_next  = LINE_BITS'(1);
            col_next   = '0;
            star_next  = 1'b0;
        end

        n = 3'd0;
        for (int i = 0; i < stl_pkg::MAX_RES; i++)
            res[i] = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (sv[i] && n < 3'(stl_pkg::MAX_RES))
            begin
                res[n[1:0]] = sr[i];
                n = n + 3'd1;
            end
        end
        if (n != 3'd0)
            res[n[1:0] - 2'd1].last = 1'b1;
        res_n = n[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stl_pkg::M_IDLE;
            plen_reg  <= '0;
            pover_reg <= 1'b0;
            kwc_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= '0;
            star_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            plen_reg  <= plen_next;
            pover_reg <= pover_next;
            kwc_reg   <= kwc_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            star_reg  <= star_next;
        end
    end

endmodule

[src/stl_fifo.sv]
`timescale 1ns / 1ps
// result queue taking up to three token results per cycle, one out per transfer
// depends on stl_pkg
module stl_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    push_n,
    input  stl_pkg::res_t push_data [stl_pkg::MAX_RES],
    input  logic          pop,
    output logic          out_valid,
    output stl_pkg::res_t out_data,
    output logic          room,
    output logic [2:0]    level
);

    stl_pkg::res_t mem [stl_pkg::FIFO_DEPTH];
    logic [1:0]    wp_reg, rp_reg;
    logic [2:0]    cnt_reg;
    logic          do_pop;

    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = mem[rp_reg];
    assign do_pop    = pop && out_valid;
    assign room      = (cnt_reg <= 3'(stl_pkg::FIFO_DEPTH - stl_pkg::MAX_RES));
    assign level     = cnt_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < stl_pkg::MAX_RES; i++)
        begin
            if (2'(i) < push_n)
                mem[wp_reg + 2'(i)] <= push_data[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + push_n;
            rp_reg  <= rp_reg + {1'b0, do_pop};
            cnt_reg <= cnt_reg + {1'b0, push_n} - {2'b00, do_pop};
        end
    end

endmodule

[bench/source_text_lexer_top_tb.sv]
`timescale 1ns / 1ps
// self-checking bench for source_text_lexer_top: byte stream in, token descriptors out
// depends on stl_pkg and source_text_lexer_top; expected tokens come from a local lexer model
module source_text_lexer_top_tb;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        bit [4:0]  kind;
        bit [19:0] line;
        bit [15:0] col;
        bit [7:0]  len;
        bit        sat;
        bit        unterm;
        bit        last;
    } token_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;

    string kw_names [8] = '{"func", "struct", "if", "else", "while", "return", "break",
                            "continue"};
    string punct_set = "{}():,;";
    string op_set    = "+-*%=<>.[]";

    token_t    token_q[$];
    int        bytes_taken;
    int        tokens_seen;
    int        mismatches;
    int        cycles;
    int        tx_idle_pct;
    int        rx_idle_pct;
    bit        rx_hold;

    bit [2:0]  lx_mode;
    int        lx_len;
    bit        lx_over;
    bit [7:0]  lx_cand;
    bit [19:0] lx_line;
    bit [15:0] lx_col;
    bit        lx_star;
    int        step_tokens;

    source_text_lexer_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit char_space(bit [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit char_alnum(bit [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit char_oper(bit [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "=" ||
               c == "<" || c == ">" || c == "." || c == "[" || c == "]";
    endfunction

    function automatic void lexer_clear();
        lx_mode = stl_pkg::M_IDLE;
        lx_len  = 0;
        lx_over = 0;
        lx_cand = '0;
        lx_line = 20'd1;
        lx_col  = '0;
        lx_star = 0;
    endfunction

    function automatic void add_token(bit [4:0] kind, bit [15:0] col, int len, bit sat,
                                      bit unterm);
        token_t t;
        if (step_tokens >= stl_pkg::MAX_RES)
            return;
        t.kind   = kind;
        t.line   = lx_line;
        t.col    = col;
        t.len    = len[7:0];
        t.sat    = sat;
        t.unterm = unterm;
        t.last   = 0;
        token_q.push_back(t);
        step_tokens++;
    endfunction

    function automatic void grow_token();
        if (lx_len < stl_pkg::MAX_TOKEN_LEN_DEF)
            lx_len++;
        else
            lx_over = 1;
    endfunction

    function automatic void open_token(bit [2:0] mode);
        lx_mode = mode;
        lx_len  = 1;
        lx_over = 0;
    endfunction

    function automatic void close_token(bit [4:0] kind, bit [15:0] col, bit unterm);
        add_token(kind, col, lx_len, lx_over, unterm);
        lx_mode = stl_pkg::M_IDLE;
    endfunction

    function automatic void lex_byte(bit [7:0] c, bit eot);
        bit [15:0] col;
        bit        taken;
        bit        newline;
        bit        done;
        col         = lx_col;
        taken       = 0;
        newline     = 0;
        step_tokens = 0;
        if (lx_mode == stl_pkg::M_SLASH)
        begin
            if (c == "*")
            begin
                lx_mode = stl_pkg::M_BLOCK;
                lx_star = 1;
                taken   = 1;
            end
            else if (c == "/")
            begin
                lx_mode = stl_pkg::M_LINE;
                taken   = 1;
            end
            else
                open_token(stl_pkg::M_OPER);
        end
        if (!taken && lx_mode == stl_pkg::M_BLOCK)
        begin
            taken = 1;
            if (lx_star && c == "/")
            begin
                lx_mode = stl_pkg::M_IDLE;
                lx_star = 0;
            end
            else
                lx_star = (c == "*");
        end
        if (!taken && lx_mode == stl_pkg::M_LINE)
        begin
            if (c == stl_pkg::C_NL)
                lx_mode = stl_pkg::M_IDLE;
            else
                taken = 1;
        end
        if (!taken && lx_mode == stl_pkg::M_STRING)
        begin
            taken = 1;
            grow_token();
            if (c == stl_pkg::C_QUOTE)
                close_token(stl_pkg::K_STRING, 16'(col + 1), 0);
        end
        if (!taken && lx_mode == stl_pkg::M_OPER)
        begin
            if (char_oper(c))
            begin
                taken = 1;
                grow_token();
                if (c == stl_pkg::C_RBRK || lx_len >= 3)
                    close_token(stl_pkg::K_OPER, 16'(col + 1), 0);
            end
            else
                close_token(stl_pkg::K_OPER, col, 0);
        end
        if (!taken && lx_mode == stl_pkg::M_IDENT)
        begin
            if (char_alnum(c) || c == stl_pkg::C_UNDER)
            begin
                taken = 1;
                for (int k = 0; k < 8; k++)
                    if (!(lx_len < kw_names[k].len() && kw_names[k][lx_len] == c))
                        lx_cand[k] = 0;
                grow_token();
            end
            else
            begin
                done = 0;
                if (char_space(c))
                    for (int k = 0; k < 8 && !done; k++)
                        if (lx_cand[k] && kw_names[k].len() == lx_len)
                        begin
                            add_token(5'(stl_pkg::K_KEYWORD0 + k), 16'(col - lx_len),
                                      lx_len, 0, 0);
                            lx_mode = stl_pkg::M_IDLE;
                            done    = 1;
                        end
                if (!done)
                    close_token(stl_pkg::K_IDENT, col, 0);
            end
        end
        if (!taken)
        begin
            if (c == stl_pkg::C_NL)
            begin
                newline = 1;
                if (lx_line != '1)
                    lx_line++;
            end
            else if (char_space(c))
                ;
            else if (c == stl_pkg::C_SLASH)
                lx_mode = stl_pkg::M_SLASH;
            else if (c == stl_pkg::C_QUOTE)
                open_token(stl_pkg::M_STRING);
            else if (char_oper(c))
            begin
                open_token(stl_pkg::M_OPER);
                if (c == stl_pkg::C_RBRK)
                    close_token(stl_pkg::K_OPER, 16'(col + 1), 0);
            end
            else if (char_alnum(c))
            begin
                open_token(stl_pkg::M_IDENT);
                lx_cand = '0;
                for (int k = 0; k < 8; k++)
                    if (kw_names[k][0] == c)
                        lx_cand[k] = 1;
            end
            else
                for (int k = 0; k < 7; k++)
                    if (punct_set[k] == c)
                        add_token(5'(k + 1), col, 1, 0, 0);
        end
        lx_col = newline ? 16'd1 : 16'(col + 1);
        if (eot)
        begin
            if (lx_mode == stl_pkg::M_STRING)
                close_token(stl_pkg::K_STRING, lx_col, 1);
            else if (lx_mode == stl_pkg::M_OPER)
                close_token(stl_pkg::K_OPER, lx_col, 0);
            else if (lx_mode == stl_pkg::M_IDENT)
                close_token(stl_pkg::K_IDENT, lx_col, 0);
            else if (lx_mode == stl_pkg::M_SLASH)
            begin
                open_token(stl_pkg::M_OPER);
                close_token(stl_pkg::K_OPER, lx_col, 0);
            end
            add_token(stl_pkg::K_END, lx_col, 0, 0, 0);
            lexer_clear();
        end
        if (step_tokens > 0)
            token_q[token_q.size() - 1].last = 1;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("source_text_lexer_top: mismatch");
            $finish;
        end
    end

    // checks each descriptor transfer, then predicts from each byte transfer
    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            tokens_seen++;
            if (token_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token kind=%0d data=%h", m_tuser, m_tdata);
            end
            else
            begin
                want = token_q.pop_front();
                if (m_tuser != want.kind || m_tdata[19:0] != want.line ||
                    m_tdata[35:20] != want.col || m_tdata[43:36] != want.len ||
                    m_tdata[44] != want.sat || m_tdata[45] != want.unterm ||
                    m_tlast != want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"token %0d: expected kind=%0d line=%0d col=%0d len=%0d ",
                                  "sat=%0d unterm=%0d last=%0d, got kind=%0d line=%0d ",
                                  "col=%0d len=%0d sat=%0d unterm=%0d last=%0d"},
                                 tokens_seen, want.kind, want.line, want.col, want.len,
                                 want.sat, want.unterm, want.last, m_tuser, m_tdata[19:0],
                                 m_tdata[35:20], m_tdata[43:36], m_tdata[44], m_tdata[45],
                                 m_tlast);
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            lex_byte(s_tdata, s_tlast);
            bytes_taken <= bytes_taken + 1;
        end
    end

    always @(posedge clk)
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

    task automatic send_byte(bit [7:0] c, bit eot);
        int target;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        target = bytes_taken + 1;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        wait (bytes_taken >= target);
    endtask

    task automatic send_text(string s, bit eot);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot && i == s.len() - 1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic test_directed();
        send_text("{}():,;\n", 0);
        send_text("func struct if else\twhile\nreturn break continue x", 0);
        send_text(" funcs if( func_a 9lives ", 0);
        send_text("/* a*/b /*/ c /*\n*/ d // note\ne", 0);
        send_text("a+=b] [x <<=3 %..-> / y \"str\" \"a\nb\"\n", 0);
        send_byte(8'h00, 0);
        send_byte(8'hFF, 0);
        send_byte(8'h80, 0);
        send_text("@#$\"", 0);
        send_byte(8'h00, 0);
        send_byte(stl_pkg::C_QUOTE, 1);
        send_text("func", 1);
        send_text("x /", 1);
        send_text("\"open", 1);
        send_text("/* open", 1);
        send_text("<=", 1);
        drain();
    endtask

    task automatic test_long_tokens();
        for (int i = 0; i < 256; i++)
            send_byte(i == 0 ? "a" : "_", 0);
        send_byte(" ", 1);
        drain();
    endtask

    task automatic test_backpressure();
        rx_hold = 1;
        fork
            begin
                repeat (300) @(posedge clk);
                rx_hold = 0;
            end
        join_none
        for (int i = 0; i < 10; i++)
            send_text("{+]", 0);
        send_byte(";", 1);
        drain();
    endtask

    task automatic send_fragment();
        string s;
        int    n;
        case ($urandom_range(9))
            0: s = {kw_names[$urandom_range(7)], " "};
            1:
            begin
                s = "";
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range(i == 0 ? 1 : 0, 3) == 0 ? "_" :
                         "a" + $urandom_range(25)))};
                if (s[0] == "_")
                    s[0] = "k";
            end
            2:
            begin
                s = "";
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    s = {s, string'(op_set[$urandom_range(9)])};
            end
            3: s = {"\"", (($urandom_range(1)) ? "ab c" : "\n*/"), "\""};
            4: s = ($urandom_range(1)) ? "/* x*y/ */" : "// c*/\n";
            5: s = string'(punct_set[$urandom_range(6)]);
            6: s = ($urandom_range(1)) ? "\n" : " \t";
            7: s = "/ ";
            default: s = string'(8'($urandom_range(255)));
        endcase
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 0);
        if ($urandom_range(39) == 0)
            send_byte(8'($urandom_range(255)), 1);
    endtask

    task automatic test_random(int tx_pct, int rx_pct, int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < count; i++)
            send_fragment();
        send_byte(" ", 1);
        drain();
    endtask

    initial
    begin
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        rst_n       = 1'b0;
        rx_hold     = 0;
        bytes_taken = 0;
        tokens_seen = 0;
        mismatches  = 0;
        cycles      = 0;
        tx_idle_pct = 32;
        rx_idle_pct = 67;
        lexer_clear();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_long_tokens();
        test_backpressure();
        test_random(32, 67, 8);
        test_random(67, 32, 8);
        test_random(0, 0, 8);
        $display("lexed %0d bytes into %0d tokens: keywords, punctuators, comments,",
                 bytes_taken, tokens_seen);
        $display("strings, operators, a saturated identifier and long output stalls");
        if (mismatches == 0)
            $display("source_text_lexer_top: match");
        else
            $display("source_text_lexer_top: mismatch");
        $finish;
    end

endmodule
